// ----- rtl/core/radar_target_screen_projector_macros.svh -----
// ----------------------------------------------------------------------------
// radar_target_screen_projector_macros
// Assertion macros for the screen projector; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef RADAR_TARGET_SCREEN_PROJECTOR_MACROS_SVH
`define RADAR_TARGET_SCREEN_PROJECTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RTSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtsp: implication check failed");
// implication after a fixed number of cycles
`define RTSP_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rtsp: delayed check failed");
`else
`define RTSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RTSP_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons)
`endif

`endif

// ----- rtl/core/rtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtsp_pkg
// Widths, register map, range compression table and payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtsp_pkg;

  localparam int COORD_W    = 16;
  localparam int CFG_W      = 10;
  localparam int ADDR_W     = 4;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int RNG_W      = 24;           // range, Q.8 mm
  localparam int RADICAND_W = 2 * RNG_W;
  localparam int SEG_W      = 2;
  localparam int SLOPE_W    = 9;
  localparam int TERM_W     = 31;
  localparam int SCALE_W    = 21;
  localparam int RAD_W      = 20;           // display radius, Q.8 pixels
  localparam int PROD_W     = SCALE_W + RAD_W;
  localparam int OFF_W      = 12;           // offset magnitude, pixels
  localparam int NUMP_W     = OFF_W + RNG_W;
  localparam int SUM_W      = 18;

  // radius scaling: estimate from the product's upper bits, fixed up
  // from the remainder's low bits (estimate is at most three short)
  localparam int PH_SHIFT    = PROD_W - RAD_W;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int DREM_W      = 24;

  localparam logic [SCALE_W-1:0] SCALE_DIV = 21'd2000000;
  // floor(2**34 / 15625), i.e. 2**21 / 2000000 scaled by 2**20
  localparam logic [RECIP_W-1:0] SCALE_RECIP = 21'd1099511;
  localparam logic [DREM_W-1:0]  SCALE_X1    = 24'd2000000;
  localparam logic [DREM_W-1:0]  SCALE_X2    = 24'd4000000;
  localparam logic [DREM_W-1:0]  SCALE_X3    = 24'd6000000;

  localparam logic [REG_IDX_W-1:0] REG_SCOPE_RADIUS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_COL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_ROW   = 2'd2;

  localparam logic [CFG_W-1:0] SCOPE_RADIUS_RST = 10'd400;
  localparam logic [CFG_W-1:0] ORIGIN_COL_RST   = 10'd400;
  localparam logic [CFG_W-1:0] ORIGIN_ROW_RST   = 10'd470;

  localparam logic [SEG_W-1:0] SEG_NEAR = 2'd0;
  localparam logic [SEG_W-1:0] SEG_MID  = 2'd1;
  localparam logic [SEG_W-1:0] SEG_FAR  = 2'd2;
  localparam logic [SEG_W-1:0] SEG_TAIL = 2'd3;

  // segment start in Q.8 mm, base term (thousandths * 2000 * 256), slope
  localparam logic [RNG_W-1:0] SEG_START [4] = '{
    24'd0, 24'd512000, 24'd1024000, 24'd1536000
  };
  localparam logic [TERM_W-1:0] SEG_BASE [4] = '{
    31'd0, 31'd256000000, 31'd384000000, 31'd460800000
  };
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [4] = '{
    9'd500, 9'd250, 9'd150, 9'd100
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pix_col;
    logic signed [COORD_W-1:0] pix_row;
  } out_res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } sq_tag_t;

  typedef struct packed {
    logic [RNG_W-1:0]   rng;
    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
  } rad_tag_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } proj_tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/rtsp_isqrt.sv -----
// ----------------------------------------------------------------------------
// rtsp_isqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtsp_isqrt #(
  parameter int ROOT_W = 24,
  parameter int TAG_W  = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  vld_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [TAG_W-1:0]      tag_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              vld_r   [ROOT_W];
  logic [RAD_W-1:0]  rad_r   [ROOT_W];
  logic [REM_W-1:0]  rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [TAG_W-1:0]  tag_r   [ROOT_W];

  logic              vld_nxt  [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [TAG_W-1:0]  tag_nxt  [ROOT_W];

  always_comb begin
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TAG_W-1:0]  tag_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        vld_in  = vld_i;
        rad_in  = rad_i;
        rem_in  = '0;
        root_in = '0;
        tag_in  = tag_i;
      end else begin
        vld_in  = vld_r[k-1];
        rad_in  = rad_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        tag_in  = tag_r[k-1];
      end
      // bring down the next bit pair, try 4*root + 1
      rem_sh = {rem_in[REM_W-3:0], rad_in[2*(ROOT_W-1-k) +: 2]};
      trial  = REM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
      rem_nxt[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt[k] = {root_in[ROOT_W-2:0], ge};
      rad_nxt[k]  = rad_in;
      tag_nxt[k]  = tag_in;
      vld_nxt[k]  = vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= vld_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      tag_r[k]  <= tag_nxt[k];
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign tag_o  = tag_r[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/rtsp_div.sv -----
// ----------------------------------------------------------------------------
// rtsp_div
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QUO_W bits (num < den * 2**QUO_W).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtsp_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 21,
  parameter int QUO_W = 20,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic             vld_r [QUO_W];
  logic [W-1:0]     rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [TAG_W-1:0] tag_r [QUO_W];

  logic             vld_nxt [QUO_W];
  logic [W-1:0]     rem_nxt [QUO_W];
  logic [DEN_W-1:0] den_nxt [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];
  logic [TAG_W-1:0] tag_nxt [QUO_W];

  always_comb begin
    logic             vld_in;
    logic [W-1:0]     rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [W-1:0]     sh;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        vld_in = vld_i;
        rem_in = W'(num_i);
        den_in = den_i;
        quo_in = '0;
        tag_in = tag_i;
      end else begin
        vld_in = vld_r[k-1];
        rem_in = rem_r[k-1];
        den_in = den_r[k-1];
        quo_in = quo_r[k-1];
        tag_in = tag_r[k-1];
      end
      sh = W'(den_in) << (QUO_W - 1 - k);
      ge = (rem_in >= sh);
      rem_nxt[k] = ge ? (rem_in - sh) : rem_in;
      quo_nxt[k] = {quo_in[QUO_W-2:0], ge};
      den_nxt[k] = den_in;
      tag_nxt[k] = tag_in;
      vld_nxt[k] = vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= vld_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_nxt[k];
      quo_r[k] <= quo_nxt[k];
      tag_r[k] <= tag_nxt[k];
    end
  end

  assign vld_o = vld_r[QUO_W-1];
  assign quo_o = quo_r[QUO_W-1];
  assign tag_o = tag_r[QUO_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/radar_target_screen_projector.sv -----
// ----------------------------------------------------------------------------
// radar_target_screen_projector
// Maps a radar target (x, y in mm) to a scope pixel with range compression.
// ----------------------------------------------------------------------------
//  channel   ports                                   flow
//  request   start, busy, in_data                    in, taken when start & !busy
//  result    out_valid, out_data                     out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,   APB, pready always high
//            prdata, pready
//
//  One request per clock; busy is always low. Stages in order: squares, sum
//  of squares, 24-stage square root, compression (segment select, base plus
//  slope, radius scale), radius scaling by reciprocal (estimate, back-multiply,
//  correction), projection multiply, 12-stage projection dividers, output.
//  Synchronous reset clears the valid pipeline and loads register defaults.
//  Results cannot be stalled, so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "radar_target_screen_projector_macros.svh"

module radar_target_screen_projector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rtsp_pkg::in_req_t            in_data,
  output logic                         out_valid,
  output rtsp_pkg::out_res_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import rtsp_pkg::*;

  localparam int LAT = 2 + RNG_W + 3 + 3 + 1 + OFF_W + 1;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32767);
    lo = -SUM_W'(32768);
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return v[COORD_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] radius_r;
  logic [CFG_W-1:0] origin_col_r;
  logic [CFG_W-1:0] origin_row_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= SCOPE_RADIUS_RST;
      origin_col_r <= ORIGIN_COL_RST;
      origin_row_r <= ORIGIN_ROW_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_SCOPE_RADIUS: radius_r     <= pwdata[CFG_W-1:0];
        REG_ORIGIN_COL:   origin_col_r <= pwdata[CFG_W-1:0];
        REG_ORIGIN_ROW:   origin_row_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_SCOPE_RADIUS: prdata = 32'(radius_r);
      REG_ORIGIN_COL:   prdata = 32'(origin_col_r);
      REG_ORIGIN_ROW:   prdata = 32'(origin_row_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------- stage 1: squares ----------------
  logic                      in_fire;
  logic signed [SQ_W-1:0]    xx_s;
  logic signed [SQ_W-1:0]    yy_s;
  logic                      v1_r;
  logic [SQ_W-1:0]           xx_r;
  logic [SQ_W-1:0]           yy_r;
  sq_tag_t                   t1_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;
  assign xx_s    = in_data.pos_x * in_data.pos_x;
  assign yy_s    = in_data.pos_y * in_data.pos_y;

  // ---------------- stage 2: sum of squares ----------------
  logic            v2_r;
  logic [SQ_W-1:0] sq_r;
  sq_tag_t         t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    xx_r   <= unsigned'(xx_s);
    yy_r   <= unsigned'(yy_s);
    t1_r.x <= in_data.pos_x;
    t1_r.y <= in_data.pos_y;
    sq_r   <= xx_r + yy_r;
    t2_r   <= t1_r;
  end

  // ---------------- square root: range in Q.8 mm ----------------
  logic [RADICAND_W-1:0] rad;
  logic                  rt_vld;
  logic [RNG_W-1:0]      rt_root;
  sq_tag_t               rt_tag;

  assign rad = {sq_r, {(RADICAND_W - SQ_W){1'b0}}};

  rtsp_isqrt #(
    .ROOT_W (RNG_W),
    .TAG_W  ($bits(sq_tag_t))
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v2_r),
    .rad_i  (rad),
    .tag_i  (t2_r),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .tag_o  (rt_tag)
  );

  // ---------------- compression stage 1: segment select ----------------
  logic [SEG_W-1:0]   seg_s;
  logic               c1_vld_r;
  logic [SEG_W-1:0]   c1_seg_r;
  logic [RNG_W-1:0]   c1_d_r;
  rad_tag_t           c1_tag_r;

  always_comb begin
    if (rt_root <= SEG_START[SEG_MID])       seg_s = SEG_NEAR;
    else if (rt_root <= SEG_START[SEG_FAR])  seg_s = SEG_MID;
    else if (rt_root <= SEG_START[SEG_TAIL]) seg_s = SEG_FAR;
    else                                     seg_s = SEG_TAIL;
  end

  always_ff @(posedge clk) begin
    c1_seg_r       <= seg_s;
    c1_d_r         <= rt_root - SEG_START[seg_s];
    c1_tag_r.rng   <= rt_root;
    c1_tag_r.mag_x <= rt_tag.x[COORD_W-1] ? COORD_W'(-rt_tag.x) : COORD_W'(rt_tag.x);
    c1_tag_r.mag_y <= rt_tag.y[COORD_W-1] ? COORD_W'(-rt_tag.y) : COORD_W'(rt_tag.y);
    c1_tag_r.neg_x <= rt_tag.x[COORD_W-1];
    c1_tag_r.neg_y <= rt_tag.y[COORD_W-1];
    c1_tag_r.zero  <= (rt_root == '0);
  end

  // ---------------- compression stage 2: base + slope * offset ----------------
  logic [SLOPE_W+RNG_W-1:0] slope_prod;
  logic                     c2_vld_r;
  logic [TERM_W-1:0]        c2_term_r;
  rad_tag_t                 c2_tag_r;

  assign slope_prod = SEG_SLOPE[c1_seg_r] * c1_d_r;

  always_ff @(posedge clk) begin
    c2_term_r <= SEG_BASE[c1_seg_r] + slope_prod[TERM_W-1:0];
    c2_tag_r  <= c1_tag_r;
  end

  // ---------------- compression stage 3: scale by scope radius ----------------
  logic [PROD_W-1:0] scale_prod;
  logic              c3_vld_r;
  logic [PROD_W-1:0] c3_prod_r;
  rad_tag_t          c3_tag_r;

  assign scale_prod = radius_r * c2_term_r;

  always_ff @(posedge clk) begin
    c3_prod_r <= scale_prod;
    c3_tag_r  <= c2_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= rt_vld;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
    end
  end

  // ---------------- display radius = product / 2000000 ----------------
  // estimate from the upper product bits, then add back up to three steps
  logic             dr_vld;
  logic [RAD_W-1:0] dr_quo;
  rad_tag_t         dr_tag;

  logic [RAD_W-1:0]  ph_s;
  logic [PROD_W-1:0] est_s;
  logic              d1_vld_r;
  logic [PROD_W-1:0] d1_est_r;
  logic [DREM_W-1:0] d1_plo_r;
  rad_tag_t          d1_tag_r;

  assign ph_s  = c3_prod_r[PROD_W-1:PH_SHIFT];
  assign est_s = ph_s * SCALE_RECIP;

  always_ff @(posedge clk) begin
    d1_est_r <= est_s;
    d1_plo_r <= c3_prod_r[DREM_W-1:0];
    d1_tag_r <= c3_tag_r;
  end

  logic [RAD_W-1:0]  qe_s;
  logic [PROD_W-1:0] qd_s;
  logic              d2_vld_r;
  logic [RAD_W-1:0]  d2_qe_r;
  logic [DREM_W-1:0] d2_qd_r;
  logic [DREM_W-1:0] d2_plo_r;
  rad_tag_t          d2_tag_r;

  assign qe_s = d1_est_r[RECIP_SHIFT+RAD_W-1:RECIP_SHIFT];
  assign qd_s = qe_s * SCALE_DIV;

  always_ff @(posedge clk) begin
    d2_qe_r  <= qe_s;
    d2_qd_r  <= qd_s[DREM_W-1:0];
    d2_plo_r <= d1_plo_r;
    d2_tag_r <= d1_tag_r;
  end

  // remainder is below 4 * 2000000, so its low bits are enough
  logic [DREM_W-1:0] rem_s;
  logic [1:0]        fix_s;
  logic              d3_vld_r;
  logic [RAD_W-1:0]  d3_quo_r;
  rad_tag_t          d3_tag_r;

  assign rem_s = d2_plo_r - d2_qd_r;
  assign fix_s = 2'(rem_s >= SCALE_X1) + 2'(rem_s >= SCALE_X2) + 2'(rem_s >= SCALE_X3);

  always_ff @(posedge clk) begin
    d3_quo_r <= d2_qe_r + RAD_W'(fix_s);
    d3_tag_r <= d2_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
      d3_vld_r <= 1'b0;
    end else begin
      d1_vld_r <= c3_vld_r;
      d2_vld_r <= d1_vld_r;
      d3_vld_r <= d2_vld_r;
    end
  end

  assign dr_vld = d3_vld_r;
  assign dr_quo = d3_quo_r;
  assign dr_tag = d3_tag_r;

  // ---------------- projection multiply ----------------
  logic [NUMP_W-1:0] nx_s;
  logic [NUMP_W-1:0] ny_s;
  logic              m1_vld_r;
  logic [NUMP_W-1:0] m1_nx_r;
  logic [NUMP_W-1:0] m1_ny_r;
  logic [RNG_W-1:0]  m1_rng_r;
  proj_tag_t         m1_tx_r;
  proj_tag_t         m1_ty_r;

  assign nx_s = dr_quo * dr_tag.mag_x;
  assign ny_s = dr_quo * dr_tag.mag_y;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else        m1_vld_r <= dr_vld;
  end

  always_ff @(posedge clk) begin
    m1_nx_r      <= nx_s;
    m1_ny_r      <= ny_s;
    m1_rng_r     <= dr_tag.rng;
    m1_tx_r.neg  <= dr_tag.neg_x;
    m1_tx_r.zero <= dr_tag.zero;
    m1_ty_r.neg  <= dr_tag.neg_y;
    m1_ty_r.zero <= dr_tag.zero;
  end

  // ---------------- offsets = radius * |coord| / range ----------------
  logic             qx_vld;
  logic             qy_vld;
  logic [OFF_W-1:0] qx_quo;
  logic [OFF_W-1:0] qy_quo;
  proj_tag_t        qx_tag;
  proj_tag_t        qy_tag;

  rtsp_div #(
    .NUM_W (NUMP_W),
    .DEN_W (RNG_W),
    .QUO_W (OFF_W),
    .TAG_W ($bits(proj_tag_t))
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (m1_vld_r),
    .num_i (m1_nx_r),
    .den_i (m1_rng_r),
    .tag_i (m1_tx_r),
    .vld_o (qx_vld),
    .quo_o (qx_quo),
    .tag_o (qx_tag)
  );

  rtsp_div #(
    .NUM_W (NUMP_W),
    .DEN_W (RNG_W),
    .QUO_W (OFF_W),
    .TAG_W ($bits(proj_tag_t))
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (m1_vld_r),
    .num_i (m1_ny_r),
    .den_i (m1_rng_r),
    .tag_i (m1_ty_r),
    .vld_o (qy_vld),
    .quo_o (qy_quo),
    .tag_o (qy_tag)
  );

  // ---------------- output: origin +/- offsets, saturated ----------------
  logic signed [SUM_W-1:0] dx;
  logic signed [SUM_W-1:0] dy;
  logic signed [SUM_W-1:0] col_sum;
  logic signed [SUM_W-1:0] row_sum;
  logic                    out_valid_r;
  out_res_t                out_data_r;

  always_comb begin
    // zero range: divider output is meaningless, target sits on the origin
    if (qx_tag.zero)     dx = '0;
    else if (qx_tag.neg) dx = -signed'(SUM_W'(qx_quo));
    else                 dx = signed'(SUM_W'(qx_quo));
    if (qy_tag.zero)     dy = '0;
    else if (qy_tag.neg) dy = -signed'(SUM_W'(qy_quo));
    else                 dy = signed'(SUM_W'(qy_quo));
    col_sum = signed'(SUM_W'(origin_col_r)) + dx;
    row_sum = signed'(SUM_W'(origin_row_r)) - dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= qx_vld && qy_vld;
  end

  always_ff @(posedge clk) begin
    out_data_r.pix_col <= sat16(col_sum);
    out_data_r.pix_row <= sat16(row_sum);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  `RTSP_ASSERT_DELAY(a_req_gives_result, clk, rst_n, in_fire, LAT, out_valid)
  `RTSP_ASSERT_IMPL(a_result_had_req, clk, rst_n, out_valid, $past(in_fire, LAT))
  `RTSP_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, qx_vld || qy_vld,
                    qx_vld && qy_vld && (qx_tag.zero == qy_tag.zero))

endmodule

`default_nettype wire

// ----- test/tb_radar_target_screen_projector.sv -----
// ----------------------------------------------------------------------------
// tb_radar_target_screen_projector
// Self-checking bench: drives target positions and APB register writes,
// predicts each pixel in software and compares every result strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rtsp_pkg::*;

class pixel_scoreboard;
  int radius_px;
  int col0;
  int row0;
  int failures;
  out_res_t pending_pixels[$];

  function new();
    radius_px = SCOPE_RADIUS_RST;
    col0      = ORIGIN_COL_RST;
    row0      = ORIGIN_ROW_RST;
    failures  = 0;
  endfunction

  function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_SCOPE_RADIUS: radius_px = data[CFG_W-1:0];
      REG_ORIGIN_COL:   col0      = data[CFG_W-1:0];
      REG_ORIGIN_ROW:   row0      = data[CFG_W-1:0];
      default: ;
    endcase
  endfunction

  function longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // piecewise-linear range compression, Q.8 mm in, Q.8 pixels out
  function longint unsigned radius_curve(longint unsigned rng);
    longint unsigned s, b, l;
    if (rng <= 64'd512000) begin
      s = 0;    b = 0;   l = 500;
    end else if (rng <= 64'd1024000) begin
      s = 2000; b = 500; l = 250;
    end else if (rng <= 64'd1536000) begin
      s = 4000; b = 750; l = 150;
    end else begin
      s = 6000; b = 900; l = 100;
    end
    return (longint'(radius_px) * (b * 512000 + l * (rng - s * 256))) / 2000000;
  endfunction

  function longint toward_zero(longint unsigned rad, longint c, longint unsigned rng);
    longint unsigned mag;
    longint q;
    mag = (c < 0) ? -c : c;
    q = (rad * mag) / rng;
    return (c < 0) ? -q : q;
  endfunction

  function logic signed [COORD_W-1:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  function out_res_t screen_pixel(in_req_t t);
    longint x, y, dx, dy;
    longint unsigned rng, rad;
    out_res_t p;
    x = t.pos_x;
    y = t.pos_y;
    rng = root_floor(longint'(x * x + y * y) << 16);
    dx = 0;
    dy = 0;
    if (rng != 0) begin
      rad = radius_curve(rng);
      dx = toward_zero(rad, x, rng);
      dy = toward_zero(rad, y, rng);
    end
    p.pix_col = clip16(longint'(col0) + dx);
    p.pix_row = clip16(longint'(row0) - dy);
    return p;
  endfunction

  function void note_target(in_req_t t);
    pending_pixels.push_back(screen_pixel(t));
  endfunction

  function void check_pixel(out_res_t got);
    out_res_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result: pix_col %0d pix_row %0d", got.pix_col, got.pix_row);
      failures++;
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pix_col !== want.pix_col) begin
      $error("pix_col mismatch: expected %0d, actual %0d", want.pix_col, got.pix_col);
      failures++;
    end
    if (got.pix_row !== want.pix_row) begin
      $error("pix_row mismatch: expected %0d, actual %0d", want.pix_row, got.pix_row);
      failures++;
    end
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction
endclass

module tb_radar_target_screen_projector;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 80;   // pipeline is 46 deep

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_req_t           in_data = '0;
  logic              out_valid;
  out_res_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned cycles = 0;
  pixel_scoreboard sb = new();

  radar_target_screen_projector dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_target(in_data);
      if (out_valid) sb.check_pixel(out_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** radar_target_screen_projector: FAILED **");
      $finish;
    end
  end

  task automatic send_target(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    in_req_t t;
    t.pos_x = x;
    t.pos_y = y;
    start <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // advance the clock first so the last accepted request is already on the scoreboard
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // junk above bit 9 must be dropped; index 3 must be ignored
  task automatic apply_setting(int rad, int col, int row);
    cfg_write(REG_SCOPE_RADIUS, (32'($urandom) << CFG_W) | 32'(rad));
    cfg_write(REG_ORIGIN_COL, (32'($urandom) << CFG_W) | 32'(col));
    cfg_write(REG_ORIGIN_ROW, (32'($urandom) << CFG_W) | 32'(row));
    cfg_write(REG_UNUSED, $urandom);
    @(posedge clk);
  endtask

  task automatic random_target();
    int x, y, m;
    case ($urandom_range(3))
      0: begin
        x = $urandom;
        y = $urandom;
      end
      1: begin
        x = int'($urandom_range(16000)) - 8000;
        y = int'($urandom_range(16000)) - 8000;
      end
      2: begin
        x = int'($urandom_range(100)) - 50;
        y = int'($urandom_range(100)) - 50;
      end
      default: begin
        // hug a segment boundary along one axis
        m = 2000 * int'($urandom_range(1, 3)) + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) m = -m;
        x = int'($urandom_range(2)) - 1;
        y = m;
        if ($urandom_range(1)) begin
          y = x;
          x = m;
        end
      end
    endcase
    send_target(x[COORD_W-1:0], y[COORD_W-1:0]);
  endtask

  task automatic run_phase(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      if ((i % 40) >= 8) begin
        while ($urandom_range(99) < idle_pct) idle_cycle();
      end
      random_target();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero range, field extremes, segment edges
    send_target(0, 0);
    send_target(16'sh7fff, 0);
    send_target(16'sh8000, 0);
    send_target(0, 16'sh7fff);
    send_target(0, 16'sh8000);
    send_target(16'sh7fff, 16'sh7fff);
    send_target(16'sh8000, 16'sh8000);
    send_target(16'sh8000, 16'sh7fff);
    send_target(16'sh7fff, 16'sh8000);
    send_target(1, 0);
    send_target(0, 1);
    send_target(-1, -1);
    send_target(0, 2000);
    send_target(2000, 0);
    send_target(0, 2001);
    send_target(0, 4000);
    send_target(-4001, 0);
    send_target(0, 6000);
    send_target(0, -6001);
    send_target(3, 4);
    send_target(-1200, 1600);
    send_target(-16'sd5555, 16'sd21845);
    drain();

    run_phase(175, 0);
    apply_setting(1023, 1023, 1023);
    run_phase(175, 87);
    apply_setting(1, 0, 0);
    run_phase(175, 28);
    // zero radius: everything lands on the origin
    apply_setting(0, 512, 300);
    run_phase(175, 0);
    apply_setting($urandom_range(1, 1023), $urandom_range(1023), $urandom_range(1023));
    run_phase(175, 87);
    apply_setting($urandom_range(1, 1023), $urandom_range(1023), $urandom_range(1023));
    run_phase(175, 28);
    apply_setting(SCOPE_RADIUS_RST, ORIGIN_COL_RST, ORIGIN_ROW_RST);
    run_phase(175, 0);
    apply_setting(1023, 0, 1023);
    run_phase(175, 28);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("** radar_target_screen_projector: PASSED **");
    end else begin
      $display("** radar_target_screen_projector: FAILED **");
    end
    $finish;
  end

endmodule
